@@ design/ttmp_pkg.sv @@
package ttmp_pkg;

   // fixed field widths
   localparam int PenW        = 8;
   localparam int TileCoordW  = 6;
   localparam int MaskByteW   = 8;
   localparam int MaskLineW   = 11;
   localparam int ByteOffsetW = 8;
   localparam int ClassW      = 2;
   localparam int GeomW       = 6;
   localparam int MaskW       = 32;

   // configuration port
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 32;

   // tile map wraps at this many tiles per side
   localparam int MapTilesPerSide = 64;

   // eight pens to a byte
   localparam logic [2:0] LastBit = 3'd7;

   // mask mode: pens from here up are always opaque
   localparam int MaskPens = 32;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_COMPARE_MODE      = 3'd0,
      CSR_TRANSPARENT_PEN   = 3'd1,
      CSR_TRANSPARENCY_MASK = 3'd2,
      CSR_TILE_WIDTH        = 3'd3,
      CSR_TILE_HEIGHT       = 3'd4
   } csr_index_type;

   typedef enum logic [ClassW-1:0] {
      CLASS_TRANSPARENT = 2'd0,
      CLASS_OPAQUE      = 2'd1,
      CLASS_MASKED      = 2'd2
   } tile_class_type;

endpackage

@@ design/ttmp_req_if.sv @@
interface ttmp_req_if import ttmp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PenW-1:0]       pen;
   logic                  flip_x;
   logic                  flip_y;
   logic [TileCoordW-1:0] tile_col;
   logic [TileCoordW-1:0] tile_row;

   modport source (output valid, pen, flip_x, flip_y, tile_col, tile_row, input ready);
   modport sink   (input valid, pen, flip_x, flip_y, tile_col, tile_row, output ready);
endinterface

@@ design/ttmp_rsp_if.sv @@
interface ttmp_rsp_if import ttmp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [MaskByteW-1:0]   mask_byte;
   logic [MaskLineW-1:0]   mask_line;
   logic [ByteOffsetW-1:0] byte_offset;
   logic                   last;
   logic [ClassW-1:0]      tile_class;

   modport source (output valid, mask_byte, mask_line, byte_offset, last, tile_class,
                   input ready);
   modport sink   (input valid, mask_byte, mask_line, byte_offset, last, tile_class,
                   output ready);
endinterface

@@ design/tile_transparency_mask_packer_core.sv @@
// tile transparency mask packer: takes one pen per clock in row-major order and turns
// each into an opacity bit (pen mode: pen differs from the transparent pen; mask mode:
// the pen's bit in the transparency mask is clear, pens of 32 and up opaque). every
// eighth transaction on req completes a mask byte, which leaves on rsp together with
// its mask line and byte offset; horizontal flip reverses bit and byte order within
// a row, vertical flip mirrors the line, and the tile's final byte carries last and
// the tile class (transparent, opaque, masked). one pen is taken every clock while
// rsp keeps up; a pen passes through the input register and its byte through the
// result register on the way from req to rsp. the result register is the only thing
// that can hold the input back, and only on a pen that completes a byte while the
// previous byte is still unread. flip flags and tile coordinates come from the pen
// that completes the byte. writing tile width or tile height restarts the tile;
// configuration is to be written while idle, which the block itself does not enforce.
module tile_transparency_mask_packer_core
   import ttmp_pkg::*;
#(
   parameter int MAX_TILE_SIZE = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   ttmp_req_if.sink             req,
   ttmp_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   // geometry limits derived from the largest tile
   localparam int BprMax = MAX_TILE_SIZE / 8;
   localparam int ByteW  = (BprMax > 1) ? $clog2(BprMax) : 1;
   localparam int BprW   = $clog2(BprMax + 1);
   localparam int LineW  = $clog2(MAX_TILE_SIZE);
   localparam int HgtW   = $clog2(MAX_TILE_SIZE + 1);
   localparam int LineCalcW = HgtW + TileCoordW;
   localparam int OffsCalcW = BprW + TileCoordW;

   function automatic logic [MaskByteW-1:0] reverse_byte(input logic [MaskByteW-1:0] v);
      logic [MaskByteW-1:0] r;
      for (int i = 0; i < MaskByteW; i++) begin
         r[i] = v[MaskByteW-1-i];
      end
      return r;
   endfunction

   // configuration registers
   logic                compare_mode_ff;
   logic [PenW-1:0]     transparent_pen_ff;
   logic [MaskW-1:0]    transparency_mask_ff;
   logic [BprW-1:0]     bpr_ff;       // clamped bytes per row
   logic [HgtW-1:0]     lines_ff;     // clamped lines per tile
   logic [BprW-1:0]     bpr_in;
   logic [HgtW-1:0]     lines_in;
   logic [GeomW-1:0]    csr_geom;
   logic [2:0]          csr_bytes;
   logic                geom_write;

   // input register
   logic                  s0_valid_ff;
   logic                  s0_valid_in;
   logic [PenW-1:0]       s0_pen_ff;
   logic                  s0_flip_x_ff;
   logic                  s0_flip_y_ff;
   logic [TileCoordW-1:0] s0_col_ff;
   logic [TileCoordW-1:0] s0_row_ff;

   // packing state
   logic [MaskByteW-1:0] shifter_ff, shifter_in;
   logic [2:0]           bit_cnt_ff, bit_cnt_in;
   logic [ByteW-1:0]     byte_cnt_ff, byte_cnt_in;
   logic [LineW-1:0]     line_cnt_ff, line_cnt_in;
   logic                 all_clear_ff, all_clear_in;
   logic                 all_set_ff, all_set_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MaskByteW-1:0]   mask_byte_ff, mask_byte_in;
   logic [MaskLineW-1:0]   mask_line_ff, mask_line_in;
   logic [ByteOffsetW-1:0] byte_offset_ff, byte_offset_in;
   logic                   last_ff, last_in;
   tile_class_type         tile_class_ff, tile_class_in;

   // handshake and step control
   logic produce;
   logic out_free;
   logic s0_fire;
   logic rsp_load;
   logic req_fire;

   // datapath
   logic                  opaque;
   logic [MaskByteW-1:0]  shifted;
   logic [MaskByteW-1:0]  data;
   logic                  clear_next;
   logic                  set_next;
   logic [TileCoordW-1:0] col_wrap;
   logic [TileCoordW-1:0] row_wrap;
   logic [HgtW-1:0]       line_sel;
   logic [BprW-1:0]       byte_sel;
   logic [LineCalcW-1:0]  line_calc;
   logic [OffsCalcW-1:0]  offs_calc;
   logic                  row_end;
   logic                  tile_end;

   // ---------------------------------------------------------------------------
   // handshake: the input register moves on unless it completes a byte while the
   // result register is full and not being read
   // ---------------------------------------------------------------------------
   assign produce  = s0_valid_ff && (bit_cnt_ff == LastBit);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s0_fire  = s0_valid_ff && (!produce || out_free);
   assign rsp_load = s0_fire && produce;
   assign req.ready = !s0_valid_ff || s0_fire;
   assign req_fire  = req.valid && req.ready;

   assign s0_valid_in  = req_fire ? 1'b1 : (s0_fire ? 1'b0 : s0_valid_ff);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // ---------------------------------------------------------------------------
   // configuration: geometry is clamped once at write time
   // ---------------------------------------------------------------------------
   assign csr_geom   = csr_wdata[GeomW-1:0];
   assign csr_bytes  = csr_geom[GeomW-1:3];
   assign geom_write = csr_we &&
                       ((csr_index == CSR_TILE_WIDTH) || (csr_index == CSR_TILE_HEIGHT));

   always_comb begin
      // width below eight acts as eight, remainder dropped, capped at the largest tile
      if (csr_bytes == 3'd0) begin
         bpr_in = BprW'(1);
      end else if (32'(csr_bytes) > 32'(BprMax)) begin
         bpr_in = BprW'(BprMax);
      end else begin
         bpr_in = BprW'(csr_bytes);
      end
      // zero height acts as one
      if (csr_geom == '0) begin
         lines_in = HgtW'(1);
      end else if (32'(csr_geom) > 32'(MAX_TILE_SIZE)) begin
         lines_in = HgtW'(MAX_TILE_SIZE);
      end else begin
         lines_in = HgtW'(csr_geom);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_mode_ff      <= 1'b0;
         transparent_pen_ff   <= '0;
         transparency_mask_ff <= '0;
         bpr_ff               <= BprW'(1);
         lines_ff             <= HgtW'(8);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COMPARE_MODE:      compare_mode_ff      <= csr_wdata[0];
            CSR_TRANSPARENT_PEN:   transparent_pen_ff   <= csr_wdata[PenW-1:0];
            CSR_TRANSPARENCY_MASK: transparency_mask_ff <= csr_wdata[MaskW-1:0];
            CSR_TILE_WIDTH:        bpr_ff               <= bpr_in;
            CSR_TILE_HEIGHT:       lines_ff             <= lines_in;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_pen_ff    <= req.pen;
         s0_flip_x_ff <= req.flip_x;
         s0_flip_y_ff <= req.flip_y;
         s0_col_ff    <= req.tile_col;
         s0_row_ff    <= req.tile_row;
      end
   end

   // ---------------------------------------------------------------------------
   // opacity bit and byte assembly
   // ---------------------------------------------------------------------------
   always_comb begin
      if (compare_mode_ff) begin
         if (32'(s0_pen_ff) >= MaskPens) begin
            opaque = 1'b1;
         end else begin
            opaque = !transparency_mask_ff[s0_pen_ff[$clog2(MaskPens)-1:0]];
         end
      end else begin
         opaque = (s0_pen_ff != transparent_pen_ff);
      end
   end

   assign shifted = {shifter_ff[MaskByteW-2:0], opaque};
   assign data    = s0_flip_x_ff ? reverse_byte(shifted) : shifted;

   // class flags including the byte just completed
   assign clear_next = all_clear_ff && (data == '0);
   assign set_next   = all_set_ff && (data == '1);

   // map coordinates wrap at the map size
   assign col_wrap = TileCoordW'(32'(s0_col_ff) % MapTilesPerSide);
   assign row_wrap = TileCoordW'(32'(s0_row_ff) % MapTilesPerSide);

   // mirrored line and byte positions
   assign line_sel = s0_flip_y_ff ? (lines_ff - HgtW'(1) - HgtW'(line_cnt_ff))
                                  : HgtW'(line_cnt_ff);
   assign byte_sel = s0_flip_x_ff ? (bpr_ff - BprW'(1) - BprW'(byte_cnt_ff))
                                  : BprW'(byte_cnt_ff);

   assign line_calc = LineCalcW'(lines_ff) * LineCalcW'(row_wrap) + LineCalcW'(line_sel);
   assign offs_calc = OffsCalcW'(bpr_ff) * OffsCalcW'(col_wrap) + OffsCalcW'(byte_sel);

   assign row_end  = (32'(byte_cnt_ff) + 1) >= 32'(bpr_ff);
   assign tile_end = row_end && ((32'(line_cnt_ff) + 1) >= 32'(lines_ff));

   always_comb begin
      shifter_in     = shifter_ff;
      bit_cnt_in     = bit_cnt_ff;
      byte_cnt_in    = byte_cnt_ff;
      line_cnt_in    = line_cnt_ff;
      all_clear_in   = all_clear_ff;
      all_set_in     = all_set_ff;
      mask_byte_in   = data;
      mask_line_in   = MaskLineW'(line_calc);
      byte_offset_in = ByteOffsetW'(offs_calc);
      last_in        = tile_end;
      tile_class_in  = CLASS_TRANSPARENT;

      if (s0_fire) begin
         if (!produce) begin
            shifter_in = shifted;
            bit_cnt_in = bit_cnt_ff + 3'd1;
         end else begin
            shifter_in   = '0;
            bit_cnt_in   = '0;
            all_clear_in = clear_next;
            all_set_in   = set_next;
            if (!row_end) begin
               byte_cnt_in = byte_cnt_ff + ByteW'(1);
            end else begin
               byte_cnt_in = '0;
               if (!tile_end) begin
                  line_cnt_in = line_cnt_ff + LineW'(1);
               end else begin
                  // final byte: report the class and restart the tile
                  line_cnt_in  = '0;
                  all_clear_in = 1'b1;
                  all_set_in   = 1'b1;
                  if (clear_next) begin
                     tile_class_in = CLASS_TRANSPARENT;
                  end else if (set_next) begin
                     tile_class_in = CLASS_OPAQUE;
                  end else begin
                     tile_class_in = CLASS_MASKED;
                  end
               end
            end
         end
      end
   end

   // packing state; a geometry write restarts the tile
   always_ff @(posedge clock) begin
      if (reset || geom_write) begin
         shifter_ff   <= '0;
         bit_cnt_ff   <= '0;
         byte_cnt_ff  <= '0;
         line_cnt_ff  <= '0;
         all_clear_ff <= 1'b1;
         all_set_ff   <= 1'b1;
      end else begin
         shifter_ff   <= shifter_in;
         bit_cnt_ff   <= bit_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         line_cnt_ff  <= line_cnt_in;
         all_clear_ff <= all_clear_in;
         all_set_ff   <= all_set_in;
      end
   end

   // ---------------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         mask_byte_ff   <= mask_byte_in;
         mask_line_ff   <= mask_line_in;
         byte_offset_ff <= byte_offset_in;
         last_ff        <= last_in;
         tile_class_ff  <= tile_class_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.mask_byte   = mask_byte_ff;
   assign rsp.mask_line   = mask_line_ff;
   assign rsp.byte_offset = byte_offset_ff;
   assign rsp.last        = last_ff;
   assign rsp.tile_class  = tile_class_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------

   // a waiting byte is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !rsp_load)
      else $error("result register overwritten while stalled");

   // byte and line counters stay inside the tile geometry
   a_counters_in_tile: assert property (@(posedge clock) disable iff (reset)
      (32'(byte_cnt_ff) < 32'(bpr_ff)) && (32'(line_cnt_ff) < 32'(lines_ff)))
      else $error("tile counters beyond geometry");

   // the final byte leaves the tile state restarted
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_load && tile_end |=> (byte_cnt_ff == '0) && (line_cnt_ff == '0) &&
                               all_clear_ff && all_set_ff && (bit_cnt_ff == '0))
      else $error("tile state not restarted after final byte");

   // tile class is only reported on the final byte
   a_class_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_ff |-> (tile_class_ff == CLASS_TRANSPARENT))
      else $error("tile class set on a byte that is not last");

endmodule

@@ bench/ttmp_mask_checker.sv @@
module ttmp_mask_checker
   import ttmp_pkg::*;
#(
   parameter int MAX_TILE_SIZE = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   ttmp_req_if                  req,
   ttmp_rsp_if                  rsp,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   output int                   fail_count,
   output int                   pending_bytes,
   output int                   bytes_checked,
   output int                   clear_tiles,
   output int                   solid_tiles,
   output int                   masked_tiles
);

   localparam int ReportLimit = 10;

   typedef struct packed {
      logic [MaskByteW-1:0]   mask_byte;
      logic [MaskLineW-1:0]   mask_line;
      logic [ByteOffsetW-1:0] byte_offset;
      logic                   last;
      tile_class_type         tile_class;
   } mask_byte_type;

   // settings as last written
   logic             cfg_mask_mode;
   logic [PenW-1:0]  cfg_clear_pen;
   logic [MaskW-1:0] cfg_see_through;
   logic [GeomW-1:0] cfg_width;
   logic [GeomW-1:0] cfg_height;

   // packing state
   logic [MaskByteW-1:0] opacity_bits;
   logic [2:0]           pens_in_byte;
   int unsigned          row_byte;
   int unsigned          tile_line;
   logic                 tile_clear;
   logic                 tile_solid;

   mask_byte_type expected_bytes[$];

   function automatic void restart_tile();
      opacity_bits = '0;
      pens_in_byte = '0;
      row_byte     = 0;
      tile_line    = 0;
      tile_clear   = 1'b1;
      tile_solid   = 1'b1;
   endfunction

   function automatic logic pen_is_opaque(input logic [PenW-1:0] pen);
      if (cfg_mask_mode) begin
         if (pen >= MaskPens) return 1'b1;
         return !cfg_see_through[pen[4:0]];
      end
      return pen != cfg_clear_pen;
   endfunction

   function automatic logic [MaskByteW-1:0] mirror_bits(input logic [MaskByteW-1:0] bits);
      logic [MaskByteW-1:0] flipped;
      for (int i = 0; i < MaskByteW; i++) flipped[i] = bits[MaskByteW-1-i];
      return flipped;
   endfunction

   task automatic apply_csr_write(input logic [CsrIndexW-1:0] index,
                                  input logic [CsrDataW-1:0]  data);
      case (csr_index_type'(index))
         CSR_COMPARE_MODE:      cfg_mask_mode   = data[0];
         CSR_TRANSPARENT_PEN:   cfg_clear_pen   = data[PenW-1:0];
         CSR_TRANSPARENCY_MASK: cfg_see_through = data[MaskW-1:0];
         CSR_TILE_WIDTH: begin
            cfg_width = data[GeomW-1:0];
            restart_tile();
         end
         CSR_TILE_HEIGHT: begin
            cfg_height = data[GeomW-1:0];
            restart_tile();
         end
         default: ;
      endcase
   endtask

   task automatic absorb_pen(input logic [PenW-1:0]       pen,
                             input logic                  fx,
                             input logic                  fy,
                             input logic [TileCoordW-1:0] col,
                             input logic [TileCoordW-1:0] row);
      int unsigned   per_row;
      int unsigned   lines;
      int unsigned   map_col;
      int unsigned   map_row;
      mask_byte_type want;
      opacity_bits = {opacity_bits[MaskByteW-2:0], pen_is_opaque(pen)};
      if (pens_in_byte != LastBit) begin
         pens_in_byte = pens_in_byte + 3'd1;
         return;
      end
      pens_in_byte = '0;

      // out-of-range geometry is clamped
      per_row = int'(cfg_width) >> 3;
      if (per_row < 1) per_row = 1;
      if (per_row > MAX_TILE_SIZE / 8) per_row = MAX_TILE_SIZE / 8;
      lines = 32'(cfg_height);
      if (lines < 1) lines = 1;
      if (lines > MAX_TILE_SIZE) lines = MAX_TILE_SIZE;
      map_col = 32'(col) % MapTilesPerSide;
      map_row = 32'(row) % MapTilesPerSide;

      want.mask_byte = fx ? mirror_bits(opacity_bits) : opacity_bits;
      opacity_bits   = '0;
      if (want.mask_byte != 8'h00) tile_clear = 1'b0;
      if (want.mask_byte != 8'hff) tile_solid = 1'b0;

      want.mask_line   = MaskLineW'(lines * map_row + (fy ? lines - 1 - tile_line : tile_line));
      want.byte_offset = ByteOffsetW'(per_row * map_col
                                      + (fx ? per_row - 1 - row_byte : row_byte));
      want.last        = 1'b0;
      want.tile_class  = CLASS_TRANSPARENT;

      if (row_byte + 1 >= per_row) begin
         row_byte = 0;
         if (tile_line + 1 >= lines) begin
            want.last       = 1'b1;
            want.tile_class = tile_clear ? CLASS_TRANSPARENT
                                         : (tile_solid ? CLASS_OPAQUE : CLASS_MASKED);
            case (want.tile_class)
               CLASS_TRANSPARENT: clear_tiles++;
               CLASS_OPAQUE:      solid_tiles++;
               default:           masked_tiles++;
            endcase
            restart_tile();
         end else begin
            tile_line = tile_line + 1;
         end
      end else begin
         row_byte = row_byte + 1;
      end
      expected_bytes.push_back(want);
   endtask

   task automatic check_mask_byte();
      mask_byte_type seen;
      mask_byte_type want;
      seen.mask_byte   = rsp.mask_byte;
      seen.mask_line   = rsp.mask_line;
      seen.byte_offset = rsp.byte_offset;
      seen.last        = rsp.last;
      seen.tile_class  = tile_class_type'(rsp.tile_class);
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
         fail_count++;
         if (fail_count <= ReportLimit)
            $display("%0t: mask byte %h line %0d offset %0d arrived with none expected",
                     $realtime, seen.mask_byte, seen.mask_line, seen.byte_offset);
         return;
      end
      want = expected_bytes.pop_front();
      if (seen.mask_byte !== want.mask_byte || seen.mask_line !== want.mask_line
          || seen.byte_offset !== want.byte_offset || seen.last !== want.last
          || seen.tile_class !== want.tile_class) begin
         fail_count++;
         if (fail_count <= ReportLimit)
            $display({"%0t: mask byte mismatch: expected byte %h line %0d offset %0d ",
                      "last %b class %0d, got byte %h line %0d offset %0d last %b class %0d"},
                     $realtime, want.mask_byte, want.mask_line, want.byte_offset,
                     want.last, want.tile_class, seen.mask_byte, seen.mask_line,
                     seen.byte_offset, seen.last, seen.tile_class);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_mask_mode   = 1'b0;
         cfg_clear_pen   = '0;
         cfg_see_through = '0;
         cfg_width       = GeomW'(8);
         cfg_height      = GeomW'(8);
         restart_tile();
         expected_bytes.delete();
         fail_count    = 0;
         bytes_checked = 0;
         clear_tiles   = 0;
         solid_tiles   = 0;
         masked_tiles  = 0;
      end else begin
         if (csr_we) apply_csr_write(csr_index, csr_wdata);
         if (rsp.valid && rsp.ready) check_mask_byte();
         if (req.valid && req.ready)
            absorb_pen(req.pen, req.flip_x, req.flip_y, req.tile_col, req.tile_row);
      end
      pending_bytes <= expected_bytes.size();
   end

endmodule

@@ bench/testbench.sv @@
module testbench;
   import ttmp_pkg::*;

   localparam int ClockPeriod   = 12;
   localparam int ResetCycles   = 12;
   localparam int MaxTileSize   = 32;
   localparam int PhaseCount    = 8;
   localparam int PhaseItems    = 56;
   localparam int HoldPhase     = 2;
   localparam int PausePhase    = 5;
   localparam int RspLongHold   = 300;
   localparam int SettleCycles  = 4;
   localparam int WatchdogLimit = 4000;

   // how a pen is chosen for the current settings
   typedef enum int {
      PICK_CLEAR,
      PICK_SOLID,
      PICK_RANDOM,
      PICK_MIXED
   } pen_pick_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_wdata;

   ttmp_req_if req_chan ();
   ttmp_rsp_if rsp_chan ();

   int fail_count;
   int pending_bytes;
   int bytes_checked;
   int clear_tiles;
   int solid_tiles;
   int masked_tiles;

   // copy of the settings kept only to steer pen choice and tile length
   logic             gen_mask_mode;
   logic [PenW-1:0]  gen_clear_pen;
   logic [MaskW-1:0] gen_see_through;
   int               gen_bytes_per_row;
   int               gen_lines;

   int   pens_sent     = 0;
   int   phase_left    = 0;
   int   req_gap_pct   = 0;
   int   rsp_stall_pct = 0;
   logic rsp_hold_req  = 1'b0;
   int   idle_cycles   = 0;

   tile_transparency_mask_packer_core #(
      .MAX_TILE_SIZE(MaxTileSize)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // prediction and comparison live in the checker, which only watches
   ttmp_mask_checker #(
      .MAX_TILE_SIZE(MaxTileSize)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_bytes (pending_bytes),
      .bytes_checked (bytes_checked),
      .clear_tiles   (clear_tiles),
      .solid_tiles   (solid_tiles),
      .masked_tiles  (masked_tiles)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (RspLongHold - 1) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else if (rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog: any stretch with no transaction and no register write
   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no transaction for %0d cycles, %0d mask bytes outstanding",
                     WatchdogLimit, pending_bytes);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // writes every register; the geometry writes also restart the tile
   task automatic configure(input logic             mode,
                            input logic [PenW-1:0]  clear_pen,
                            input logic [MaskW-1:0] see_through,
                            input logic [GeomW-1:0] width,
                            input logic [GeomW-1:0] height);
      write_reg(CSR_COMPARE_MODE, CsrDataW'(mode));
      write_reg(CSR_TRANSPARENT_PEN, CsrDataW'(clear_pen));
      write_reg(CSR_TRANSPARENCY_MASK, CsrDataW'(see_through));
      write_reg(CSR_TILE_WIDTH, CsrDataW'(width));
      write_reg(CSR_TILE_HEIGHT, CsrDataW'(height));
      csr_we <= 1'b0;
      gen_mask_mode     = mode;
      gen_clear_pen     = clear_pen;
      gen_see_through   = see_through;
      gen_bytes_per_row = int'(width) >> 3;
      if (gen_bytes_per_row < 1) gen_bytes_per_row = 1;
      if (gen_bytes_per_row > MaxTileSize / 8) gen_bytes_per_row = MaxTileSize / 8;
      gen_lines = int'(height);
      if (gen_lines < 1) gen_lines = 1;
      if (gen_lines > MaxTileSize) gen_lines = MaxTileSize;
   endtask

   // offers one pen, maybe after a gap, and returns at the edge that takes it
   task automatic send_pen(input logic [PenW-1:0]       pen,
                           input logic                  fx,
                           input logic                  fy,
                           input logic [TileCoordW-1:0] col,
                           input logic [TileCoordW-1:0] row);
      if (req_gap_pct > 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.pen      <= pen;
      req_chan.flip_x   <= fx;
      req_chan.flip_y   <= fy;
      req_chan.tile_col <= col;
      req_chan.tile_row <= row;
      do @(posedge clock); while (!req_chan.ready);
      pens_sent++;
   endtask

   // stop offering and wait until every expected mask byte has been taken
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_bytes != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [PenW-1:0] pick_pen(input pen_pick_type style);
      pen_pick_type    kind;
      logic [PenW-1:0] pen;
      kind = (style == PICK_MIXED) ? pen_pick_type'($urandom_range(PICK_CLEAR, PICK_RANDOM))
                                   : style;
      pen  = PenW'($urandom);
      case (kind)
         PICK_CLEAR: begin
            if (!gen_mask_mode) begin
               pen = gen_clear_pen;
            end else if (gen_see_through != '0) begin
               // only small pens with their mask bit set are see-through
               pen = PenW'($urandom_range(0, MaskPens - 1));
               while (!gen_see_through[pen[4:0]]) pen = PenW'($urandom_range(0, MaskPens - 1));
            end
         end
         PICK_SOLID: begin
            if (!gen_mask_mode) pen = gen_clear_pen ^ PenW'($urandom_range(1, 255));
            else if (pen < MaskPens && gen_see_through[pen[4:0]]) pen = pen | 8'h20;
         end
         default: ;
      endcase
      return pen;
   endfunction

   // one tile with steady flags and coordinates, cut short at the phase budget
   task automatic send_tile();
      int           r;
      int           tile_pens;
      pen_pick_type style;
      logic         fx;
      logic         fy;
      logic [TileCoordW-1:0] col;
      logic [TileCoordW-1:0] row;
      r         = $urandom_range(0, 5);
      style     = (r == 0) ? PICK_CLEAR : ((r == 1) ? PICK_SOLID : PICK_MIXED);
      fx        = 1'($urandom);
      fy        = 1'($urandom);
      col       = TileCoordW'($urandom);
      row       = TileCoordW'($urandom);
      tile_pens = gen_bytes_per_row * 8 * gen_lines;
      for (int i = 0; i < tile_pens && phase_left > 0; i++) begin
         send_pen(pick_pen(style), fx, fy, col, row);
         phase_left--;
      end
   endtask

   // short run of unrelated pens, every field drawn at random for each one
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n && phase_left > 0; i++) begin
         send_pen(PenW'($urandom), 1'($urandom), 1'($urandom),
                  TileCoordW'($urandom), TileCoordW'($urandom));
         phase_left--;
      end
   endtask

   initial begin
      logic paused;
      paused             = 1'b0;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_COMPARE_MODE;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.pen      <= '0;
      req_chan.flip_x   <= 1'b0;
      req_chan.flip_y   <= 1'b0;
      req_chan.tile_col <= '0;
      req_chan.tile_row <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one-line tiles of eight pens in pen mode
      configure(1'b0, 8'h00, 32'hffff_ffff, GeomW'(8), GeomW'(1));
      // all pens transparent, no flips, map origin
      repeat (8) send_pen(8'h00, 1'b0, 1'b0, '0, '0);
      // all pens opaque, both flips, far corner of the map
      repeat (8) send_pen(8'hff, 1'b1, 1'b1, 6'd63, 6'd63);
      // alternating bits; flags and coordinates change on the completing pen
      for (int i = 0; i < 7; i++) send_pen(i[0] ? 8'h80 : 8'h00, 1'b0, 1'b1, '0, '0);
      send_pen(8'h01, 1'b1, 1'b0, 6'd63, 6'd5);
      drain();

      // random phases, each with its own settings; partial tiles left at a
      // phase end get cut off by the next geometry write
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: begin
               configure(1'b0, 8'h00, 32'h0000_0000, GeomW'(8), GeomW'(1));
               req_gap_pct   = 10;
               rsp_stall_pct = 10;
            end
            1: begin
               configure(1'b1, 8'hff, 32'hffff_ffff, GeomW'(16), GeomW'(2));
               req_gap_pct   = 25;
               rsp_stall_pct = 25;
            end
            2: begin
               // zero width and height act as the smallest tile
               configure(1'b1, PenW'($urandom), MaskW'($urandom), GeomW'(0), GeomW'(0));
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
            3: begin
               configure(1'b0, 8'hff, MaskW'($urandom), GeomW'(63), GeomW'(1));
               req_gap_pct   = 15;
               rsp_stall_pct = 30;
            end
            4: begin
               // oversize height, width not a multiple of eight
               configure(1'b0, PenW'($urandom), MaskW'($urandom), GeomW'(13), GeomW'(63));
               req_gap_pct   = 30;
               rsp_stall_pct = 15;
            end
            5: begin
               configure(1'b1, PenW'($urandom), 32'h8000_0001, GeomW'(32), GeomW'(3));
               req_gap_pct   = 10;
               rsp_stall_pct = 10;
            end
            6: begin
               configure(1'b0, PenW'($urandom), MaskW'($urandom), GeomW'(24), GeomW'(2));
               req_gap_pct   = 20;
               rsp_stall_pct = 20;
            end
            default: begin
               // closing stretch runs flat out, width below eight
               configure(1'b1, PenW'($urandom), MaskW'($urandom), GeomW'(5), GeomW'(4));
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase
         phase_left = PhaseItems;
         // result side holds off while pens keep coming, so the block backs up
         if (p == HoldPhase) rsp_hold_req = 1'b1;
         while (phase_left > 0) begin
            // halfway through one phase the sender waits for the output to empty
            if (p == PausePhase && !paused && phase_left <= PhaseItems / 2) begin
               drain();
               paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 15) send_noise();
            else send_tile();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      $display("sent %0d pens, checked %0d mask bytes, %0d mismatches",
               pens_sent, bytes_checked, fail_count);
      $display("completed tiles: %0d transparent, %0d opaque, %0d masked",
               clear_tiles, solid_tiles, masked_tiles);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
